FILE: design/circq_pkg.sv
package circq_pkg;

   localparam int MAX_SLOTS = 64;
   localparam int SLOT_W    = $clog2(MAX_SLOTS);
   localparam int CNT_W     = $clog2(MAX_SLOTS + 1);
   localparam int DATA_W    = 32;

   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_DELETE = 2'd1;
   localparam logic [1:0] OP_DUMP   = 2'd2;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_OVERFLOW  = 2'd1;
   localparam logic [1:0] ST_UNDERFLOW = 2'd2;
   localparam logic [1:0] ST_DUMP      = 2'd3;

   localparam logic [CNT_W-1:0] MIN_SLOTS_CNT = CNT_W'(2);
   localparam logic [CNT_W-1:0] MAX_SLOTS_CNT = CNT_W'(MAX_SLOTS);

endpackage

FILE: design/circular_queue_with_dump_core.sv
// Channel   Direction  Handshake            Payload
// req_      in         req_valid/req_stall  req_operation, req_value
// rsp_      out        rsp_valid/rsp_stall  rsp_status, rsp_data, rsp_slot_index, rsp_last
// csr_      in         csr_valid/csr_ready  csr_data (slot count)
//
// A fitting insert and an underflow respond from S_IDLE; unused codes give no response.
// A delete reads the slot memory in S_IDLE and responds from S_DELETE. A dump or overflow
// walks the slots, one per cycle unless stalled, via one read port; one request at a time.
// Reset and a csr write clear the per-slot valid bits at once; no clearing pass.
// rsp_stall holds the output register and the dump sequence; req_stall is high while
// a request is in flight, a csr write is waiting, or the output register cannot take
// a new response.
module circular_queue_with_dump_core (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [1:0]                      req_operation,
   input  logic signed [circq_pkg::DATA_W-1:0] req_value,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [1:0]                      rsp_status,
   output logic signed [circq_pkg::DATA_W-1:0] rsp_data,
   output logic [circq_pkg::SLOT_W-1:0]    rsp_slot_index,
   output logic                            rsp_last,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [circq_pkg::CNT_W-1:0]     csr_data
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_DELETE,
      S_DUMP
   } state_type;

   state_type                         state_ff;
   logic [circq_pkg::CNT_W-1:0]       slots_ff;
   logic [circq_pkg::SLOT_W-1:0]      head_ff;
   logic [circq_pkg::SLOT_W-1:0]      tail_ff;
   logic [circq_pkg::SLOT_W-1:0]      idx_ff;
   logic [1:0]                        dump_status_ff;
   logic [circq_pkg::MAX_SLOTS-1:0]   valid_ff;

   logic                              rsp_valid_ff;
   logic [1:0]                        rsp_status_ff;
   logic [circq_pkg::DATA_W-1:0]      rsp_data_ff;
   logic [circq_pkg::SLOT_W-1:0]      rsp_slot_ff;
   logic                              rsp_last_ff;

   logic [circq_pkg::DATA_W-1:0]      mem [circq_pkg::MAX_SLOTS];
   logic [circq_pkg::DATA_W-1:0]      rd_data_ff;
   logic                              rd_valid_ff;

   logic                              rd_en_in;
   logic [circq_pkg::SLOT_W-1:0]      rd_addr_in;
   logic                              wr_en_in;
   logic [circq_pkg::SLOT_W-1:0]      wr_addr_in;
   logic                              rsp_valid_in;

   logic                              out_free;
   logic                              req_take;
   logic                              csr_take;
   logic [circq_pkg::SLOT_W-1:0]      tail_next;
   logic [circq_pkg::SLOT_W-1:0]      tail_next2;
   logic                              q_empty;
   logic                              q_full;
   logic                              dump_last;
   logic [circq_pkg::CNT_W-1:0]       slots_in;
   logic [circq_pkg::DATA_W-1:0]      slot_value;

   function automatic logic [circq_pkg::SLOT_W-1:0] wrap_next(
      input logic [circq_pkg::SLOT_W-1:0] x,
      input logic [circq_pkg::CNT_W-1:0]  slots
   );
      logic [circq_pkg::CNT_W-1:0] n;
      n = circq_pkg::CNT_W'(x) + circq_pkg::CNT_W'(1);
      return (n >= slots) ? '0 : n[circq_pkg::SLOT_W-1:0];
   endfunction

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign req_stall  = !(state_ff == S_IDLE && out_free && !csr_valid);
   assign req_take   = req_valid && !req_stall;
   assign csr_ready  = (state_ff == S_IDLE);
   assign csr_take   = csr_valid && csr_ready;

   assign tail_next  = wrap_next(tail_ff, slots_ff);
   assign tail_next2 = wrap_next(tail_next, slots_ff);
   assign q_empty    = (tail_next == head_ff);
   assign q_full     = (tail_next2 == head_ff);
   assign dump_last  = (circq_pkg::CNT_W'(idx_ff) + circq_pkg::CNT_W'(1) == slots_ff);
   assign slot_value = rd_valid_ff ? rd_data_ff : '0;

   always_comb begin
      if (csr_data < circq_pkg::MIN_SLOTS_CNT) begin
         slots_in = circq_pkg::MIN_SLOTS_CNT;
      end else if (csr_data > circq_pkg::MAX_SLOTS_CNT) begin
         slots_in = circq_pkg::MAX_SLOTS_CNT;
      end else begin
         slots_in = csr_data;
      end
   end

   always_comb begin
      rd_en_in     = 1'b0;
      rd_addr_in   = '0;
      wr_en_in     = 1'b0;
      wr_addr_in   = tail_next;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               case (req_operation)
                  circq_pkg::OP_INSERT: begin
                     if (q_full) begin
                        rd_en_in = 1'b1;
                     end else begin
                        wr_en_in     = 1'b1;
                        rsp_valid_in = 1'b1;
                     end
                  end
                  circq_pkg::OP_DELETE: begin
                     rd_en_in   = !q_empty;
                     rd_addr_in = head_ff;
                     if (q_empty) begin
                        rsp_valid_in = 1'b1;
                     end
                  end
                  circq_pkg::OP_DUMP: begin
                     rd_en_in = 1'b1;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_DELETE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
            end
         end
         S_DUMP: begin
            rd_en_in   = out_free && !dump_last;
            rd_addr_in = idx_ff + circq_pkg::SLOT_W'(1);
            if (out_free) begin
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en_in) begin
         mem[wr_addr_in] <= req_value;
      end
      if (rd_en_in) begin
         rd_data_ff  <= mem[rd_addr_in];
         rd_valid_ff <= valid_ff[rd_addr_in];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         slots_ff       <= circq_pkg::MAX_SLOTS_CNT;
         head_ff        <= circq_pkg::SLOT_W'(1);
         tail_ff        <= '0;
         valid_ff       <= '0;
         idx_ff         <= '0;
         dump_status_ff <= circq_pkg::ST_DUMP;
         rsp_valid_ff   <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         case (state_ff)
            S_IDLE: begin
               if (csr_take) begin
                  slots_ff <= slots_in;
                  head_ff  <= circq_pkg::SLOT_W'(1);
                  tail_ff  <= '0;
                  valid_ff <= '0;
               end else if (req_take) begin
                  case (req_operation)
                     circq_pkg::OP_INSERT: begin
                        if (q_full) begin
                           idx_ff         <= '0;
                           dump_status_ff <= circq_pkg::ST_OVERFLOW;
                           state_ff       <= S_DUMP;
                        end else begin
                           tail_ff             <= tail_next;
                           valid_ff[tail_next] <= 1'b1;
                           rsp_status_ff       <= circq_pkg::ST_OK;
                           rsp_data_ff         <= '0;
                           rsp_slot_ff         <= '0;
                           rsp_last_ff         <= 1'b1;
                        end
                     end
                     circq_pkg::OP_DELETE: begin
                        if (q_empty) begin
                           rsp_status_ff <= circq_pkg::ST_UNDERFLOW;
                           rsp_data_ff   <= '0;
                           rsp_slot_ff   <= '0;
                           rsp_last_ff   <= 1'b1;
                        end else begin
                           valid_ff[head_ff] <= 1'b0;
                           head_ff           <= wrap_next(head_ff, slots_ff);
                           state_ff          <= S_DELETE;
                        end
                     end
                     circq_pkg::OP_DUMP: begin
                        idx_ff         <= '0;
                        dump_status_ff <= circq_pkg::ST_DUMP;
                        state_ff       <= S_DUMP;
                     end
                     default: begin
                     end
                  endcase
               end
            end
            S_DELETE: begin
               if (out_free) begin
                  rsp_status_ff <= circq_pkg::ST_OK;
                  rsp_data_ff   <= slot_value;
                  rsp_slot_ff   <= '0;
                  rsp_last_ff   <= 1'b1;
                  state_ff      <= S_IDLE;
               end
            end
            S_DUMP: begin
               if (out_free) begin
                  rsp_status_ff <= dump_status_ff;
                  rsp_data_ff   <= slot_value;
                  rsp_slot_ff   <= idx_ff;
                  rsp_last_ff   <= dump_last;
                  if (dump_last) begin
                     state_ff <= S_IDLE;
                  end else begin
                     idx_ff <= idx_ff + circq_pkg::SLOT_W'(1);
                  end
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_data       = rsp_data_ff;
   assign rsp_slot_index = rsp_slot_ff;
   assign rsp_last       = rsp_last_ff;

endmodule
